// ----- src/thpi_pkg.sv -----
// Package for the timed pose history interpolator.
// Holds the channel payload types, entry and cell control types, and codes.
// No dependencies.
`default_nettype none

package thpi_pkg;

	// Request codes
	localparam logic [1:0] REQ_PUSH   = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;

	// Result status codes
	localparam logic [3:0] ST_INSERTED = 4'd0;
	localparam logic [3:0] ST_OOO      = 4'd1;
	localparam logic [3:0] ST_REPLACED = 4'd2;
	localparam logic [3:0] ST_IGNORED  = 4'd3;
	localparam logic [3:0] ST_ROLLBACK = 4'd4;
	localparam logic [3:0] ST_READY    = 4'd5;
	localparam logic [3:0] ST_EMPTY    = 4'd6;
	localparam logic [3:0] ST_TOO_OLD  = 4'd7;
	localparam logic [3:0] ST_FUTURE   = 4'd8;
	localparam logic [3:0] ST_CLEARED  = 4'd9;

	// Configuration register indexes
	localparam logic [1:0] CFG_WINDOW   = 2'd0;
	localparam logic [1:0] CFG_LIMIT    = 2'd1;
	localparam logic [1:0] CFG_ROLLBACK = 2'd2;

	// Smallest entry limit, and fewest entries before window pruning applies
	localparam int MIN_HELD = 2;

	// Flips signed stamps into order-preserving unsigned keys
	localparam logic [63:0] KEY_FLIP = 64'h8000_0000_0000_0000;

	// Cell operations
	typedef logic [2:0] thpi_op_t;
	localparam thpi_op_t OP_HOLD    = 3'd0;
	localparam thpi_op_t OP_INSERT  = 3'd1;
	localparam thpi_op_t OP_REPLACE = 3'd2;
	localparam thpi_op_t OP_SHIFT   = 3'd3;
	localparam thpi_op_t OP_LOAD0   = 3'd4;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [63:0] event_stamp;
		logic signed [31:0] pose_x_in;
		logic signed [31:0] pose_y_in;
		logic signed [15:0] pose_yaw_in;
	} thpi_in_t;

	typedef struct packed {
		logic [3:0]         status;
		logic signed [31:0] pose_x_out;
		logic signed [31:0] pose_y_out;
		logic signed [15:0] pose_yaw_out;
		logic [6:0]         entry_count;
	} thpi_out_t;

	// One stored pose; key is the offset-binary stamp
	typedef struct packed {
		logic [63:0] key;
		logic [31:0] x;
		logic [31:0] y;
		logic [15:0] yaw;
	} thpi_entry_t;

	typedef struct packed {
		thpi_op_t    op;
		thpi_entry_t ent;
	} thpi_cell_ctl_t;

	typedef struct packed {
		logic ge;
		logic eq;
		logic bnd;
		logic in_use;
	} thpi_cell_st_t;

endpackage

`default_nettype wire

// ----- src/thpi_cell.sv -----
// One storage cell of the sorted pose chain.
// Compares its entry against the request key and shifts with its neighbors.
// Depends on thpi_pkg.
`default_nettype none

module thpi_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  wire logic                     clk,
	input  wire thpi_pkg::thpi_cell_ctl_t ctl,
	input  wire logic [CW-1:0]            count,
	input  wire thpi_pkg::thpi_entry_t    prev_ent,
	input  wire logic                     prev_ge,
	input  wire thpi_pkg::thpi_entry_t    next_ent,
	output thpi_pkg::thpi_entry_t         ent,
	output thpi_pkg::thpi_cell_st_t       st
);
	import thpi_pkg::*;

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	thpi_entry_t ent_q;
	logic        in_use;
	logic        lt;

	// Position and ordering flags
	assign in_use    = MY_IDX < count;
	assign lt        = ent_q.key < ctl.ent.key;
	assign st.in_use = in_use;
	assign st.ge     = !in_use || !lt;
	assign st.eq     = in_use && (ent_q.key == ctl.ent.key);
	assign st.bnd    = st.ge && !prev_ge;
	assign ent       = ent_q;

	// Entry update
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INSERT: begin
				if (st.bnd) begin
					ent_q <= ctl.ent;
				end else if (prev_ge) begin
					ent_q <= prev_ent;
				end
			end
			OP_REPLACE: begin
				if (st.eq) begin
					ent_q <= ctl.ent;
				end
			end
			OP_SHIFT: begin
				ent_q <= next_ent;
			end
			OP_LOAD0: begin
				if (IDX == 0) begin
					ent_q <= ctl.ent;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- src/thpi_scale.sv -----
// Serial scaler: round(num * mag / den) with num < den, taking mag one bit at a time, MSB first.
// Interleaves shift-add multiplication with restoring reduction modulo den: a doubling step, then an add step.
// No dependencies; it does not import thpi_pkg.
`default_nettype none

module thpi_scale #(
	parameter int MAG_W = 33
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [63:0]      num,
	input  wire logic [63:0]      den,
	input  wire logic [MAG_W-1:0] mag,
	output logic                  busy,
	output logic [MAG_W-1:0]      quo
);
	localparam int CNT_W = $clog2(MAG_W + 1);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DBL  = 2'd1;
	localparam logic [1:0] PH_ADD  = 2'd2;
	localparam logic [1:0] PH_RND  = 2'd3;

	logic [1:0]       phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic [63:0]      rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [MAG_W-1:0] mag_q;
	logic [64:0]      dbl;
	logic [64:0]      add;
	logic             dbl_ge;
	logic             add_ge;

	// Remainder stays below den after each step
	assign dbl    = {rem_q, 1'b0};
	assign dbl_ge = dbl >= {1'b0, den};
	assign add    = {1'b0, rem_q} + (mag_q[MAG_W-1] ? {1'b0, num} : 65'd0);
	assign add_ge = add >= {1'b0, den};
	assign busy   = phase_q != PH_IDLE;
	assign quo    = quo_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
		end else if (start) begin
			phase_q <= PH_DBL;
			cnt_q   <= CNT_W'(MAG_W);
		end else begin
			unique case (phase_q)
				PH_DBL: phase_q <= PH_ADD;
				PH_ADD: begin
					cnt_q   <= cnt_q - 1'b1;
					phase_q <= (cnt_q == CNT_W'(1)) ? PH_RND : PH_DBL;
				end
				PH_RND: phase_q <= PH_IDLE;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			mag_q <= mag;
		end else begin
			case (phase_q)
				PH_DBL: begin
					rem_q <= dbl_ge ? 64'(dbl - {1'b0, den}) : dbl[63:0];
					quo_q <= {quo_q[MAG_W-2:0], dbl_ge};
				end
				PH_ADD: begin
					rem_q <= add_ge ? 64'(add - {1'b0, den}) : add[63:0];
					quo_q <= quo_q + MAG_W'(add_ge);
					mag_q <= mag_q << 1;
				end
				PH_RND: begin
					// round half away from zero on the magnitude
					quo_q <= quo_q + MAG_W'(dbl_ge);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/timed_pose_history_interpolator_unit.sv -----
// Timed pose history: a sorted chain of MAX_ENTRIES+1 cells with linear lookup.
// One request is in flight at a time: in_stall stays high from the accepting
// edge until the result is loaded, and falls in the same cycle that out_valid rises.
// A clear or a lookup that needs no interpolation passes S_SEL, S_DEC and S_DONE;
// a push adds S_APPLY, and an insertion then prunes in S_PRUNE_W and S_PRUNE_L,
// one entry at a time; an interpolated lookup waits in S_DIV for the serial
// scalers, which work through the 33-bit x/y difference bit by bit.
// A stalled output holds the item in S_DONE.
// Depends on thpi_pkg, thpi_cell, thpi_scale.
`default_nettype none

module timed_pose_history_interpolator_unit #(
	parameter int MAX_ENTRIES = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire thpi_pkg::thpi_in_t in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output thpi_pkg::thpi_out_t     out_data,
	input  wire logic               cfg_en,
	input  wire logic [1:0]         cfg_addr,
	input  wire logic [62:0]        cfg_data
);
	import thpi_pkg::*;

	localparam int NCELL = MAX_ENTRIES + 1;
	localparam int CW    = $clog2(MAX_ENTRIES + 2);
	localparam int LW    = (CW > 7) ? CW : 7;
	localparam logic [CW-1:0] LIM_RESET = CW'((MAX_ENTRIES < 64) ? MAX_ENTRIES : 64);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SEL     = 3'd1;
	localparam logic [2:0] S_DEC     = 3'd2;
	localparam logic [2:0] S_APPLY   = 3'd3;
	localparam logic [2:0] S_PRUNE_W = 3'd4;
	localparam logic [2:0] S_PRUNE_L = 3'd5;
	localparam logic [2:0] S_DIV     = 3'd6;
	localparam logic [2:0] S_DONE    = 3'd7;

	// Control state
	logic [2:0]    state_q;
	logic [CW-1:0] n_q;
	logic          out_valid_q;
	logic [62:0]   win_q;
	logic [CW-1:0] lim_q;
	logic [62:0]   thr_q;
	logic          div_start_q;
	thpi_op_t      op_q;

	// Request and result registers
	logic [1:0]  req_q;
	thpi_entry_t rq_q;
	logic [3:0]  status_q;
	logic [31:0] rx_q;
	logic [31:0] ry_q;
	logic [15:0] ryaw_q;
	logic [63:0] cut_q;
	thpi_out_t   out_q;

	// Selection registers
	logic [63:0] newest_q;
	logic        eq_any_q;
	thpi_entry_t eq_ent_q;
	thpi_entry_t lo_ent_q;
	thpi_entry_t hi_ent_q;
	logic        hi_in_q;
	logic        bnd0_q;

	// Scaler operands
	logic [63:0] num_q;
	logic [63:0] den_q;
	logic [32:0] magx_q;
	logic [32:0] magy_q;
	logic [15:0] magyaw_q;
	logic        negx_q;
	logic        negy_q;
	logic        negyaw_q;

	thpi_entry_t    ent [NCELL];
	thpi_cell_st_t  st [NCELL];
	thpi_cell_ctl_t cell_ctl;
	thpi_op_t       cell_op;

	logic [63:0] newest_c;
	logic        eq_any_c;
	thpi_entry_t eq_ent_c;
	thpi_entry_t lo_ent_c;
	thpi_entry_t hi_ent_c;
	logic        hi_in_c;

	logic [63:0] cut_now;
	logic [63:0] ok_key;
	logic [63:0] newest_after;
	logic [63:0] cut_after;
	logic        rollback;
	logic        shift_w;
	logic        shift_l;
	thpi_op_t    dec_op;
	logic [3:0]  dec_status;
	logic        dec_ready;
	logic        dec_div;
	logic [32:0] dx;
	logic [32:0] dy;
	logic [15:0] dyaw;
	logic [LW-1:0] lim_w;
	logic        busy_x;
	logic        busy_y;
	logic        busy_yaw;
	logic [32:0] qx;
	logic [32:0] qy;
	logic [15:0] qyaw;
	logic        div_done;
	logic        out_free;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Cell chain
	assign cell_ctl.op  = cell_op;
	assign cell_ctl.ent = rq_q;

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		thpi_entry_t prev_e;
		thpi_entry_t next_e;
		logic        prev_g;
		if (g == 0) begin : g_first
			assign prev_e = '0;
			assign prev_g = 1'b0;
		end else begin : g_mid
			assign prev_e = ent[g-1];
			assign prev_g = st[g-1].ge;
		end
		if (g == NCELL - 1) begin : g_last
			assign next_e = '0;
		end else begin : g_inner
			assign next_e = ent[g+1];
		end
		thpi_cell #(.IDX(g), .CW(CW)) u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.count    (n_q),
			.prev_ent (prev_e),
			.prev_ge  (prev_g),
			.next_ent (next_e),
			.ent      (ent[g]),
			.st       (st[g])
		);
	end

	// One-hot picks across the chain
	always_comb begin
		newest_c = '0;
		eq_any_c = 1'b0;
		eq_ent_c = '0;
		hi_ent_c = '0;
		lo_ent_c = '0;
		hi_in_c  = 1'b0;
		for (int j = 0; j < NCELL; j++) begin
			if (CW'(j + 1) == n_q) begin
				newest_c = newest_c | ent[j].key;
			end
			if (st[j].eq) begin
				eq_any_c = 1'b1;
				eq_ent_c = eq_ent_c | ent[j];
			end
			if (st[j].bnd) begin
				hi_ent_c = hi_ent_c | ent[j];
				hi_in_c  = hi_in_c | st[j].in_use;
			end
		end
		for (int j = 0; j < NCELL - 1; j++) begin
			if (st[j+1].bnd) begin
				lo_ent_c = lo_ent_c | ent[j];
			end
		end
	end

	// Window cut and acceptance bounds
	assign cut_now      = (newest_q > {1'b0, win_q}) ? newest_q - {1'b0, win_q} : '0;
	assign ok_key       = (ent[0].key > cut_now) ? ent[0].key : cut_now;
	assign newest_after = (rq_q.key < newest_q) ? newest_q : rq_q.key;
	assign cut_after    = (newest_after > {1'b0, win_q}) ? newest_after - {1'b0, win_q} : '0;
	assign rollback     = (rq_q.key < newest_q) && ((newest_q - rq_q.key) > {1'b0, thr_q});

	// Interpolation differences
	assign dx   = {hi_ent_q.x[31], hi_ent_q.x} - {lo_ent_q.x[31], lo_ent_q.x};
	assign dy   = {hi_ent_q.y[31], hi_ent_q.y} - {lo_ent_q.y[31], lo_ent_q.y};
	assign dyaw = hi_ent_q.yaw - lo_ent_q.yaw;

	// Decision for the current request
	always_comb begin
		dec_op     = OP_HOLD;
		dec_status = ST_CLEARED;
		dec_ready  = 1'b0;
		dec_div    = 1'b0;
		case (req_q)
			REQ_PUSH: begin
				if (n_q == '0) begin
					dec_op     = OP_LOAD0;
					dec_status = ST_INSERTED;
				end else if (rollback) begin
					dec_op     = OP_LOAD0;
					dec_status = ST_ROLLBACK;
				end else if (rq_q.key < ok_key) begin
					dec_status = ST_IGNORED;
				end else if (eq_any_q) begin
					dec_op     = OP_REPLACE;
					dec_status = ST_REPLACED;
				end else begin
					dec_op     = OP_INSERT;
					dec_status = (rq_q.key < newest_q) ? ST_OOO : ST_INSERTED;
				end
			end
			REQ_LOOKUP: begin
				if (n_q == '0) begin
					dec_status = ST_EMPTY;
				end else if (rq_q.key < ok_key) begin
					dec_status = ST_TOO_OLD;
				end else if (rq_q.key > newest_q) begin
					dec_status = ST_FUTURE;
				end else if (eq_any_q) begin
					dec_status = ST_READY;
					dec_ready  = 1'b1;
				end else if (bnd0_q || !hi_in_q) begin
					dec_status = ST_TOO_OLD;
				end else begin
					dec_status = ST_READY;
					dec_div    = 1'b1;
				end
			end
			default: begin
				dec_status = ST_CLEARED;
			end
		endcase
	end

	// Pruning conditions, one entry dropped per cycle
	assign shift_w = (n_q >= CW'(MIN_HELD)) && (ent[1].key < cut_q);
	assign shift_l = n_q > lim_q;

	always_comb begin
		cell_op = OP_HOLD;
		if (state_q == S_APPLY) begin
			cell_op = op_q;
		end else if ((state_q == S_PRUNE_W) && shift_w) begin
			cell_op = OP_SHIFT;
		end else if ((state_q == S_PRUNE_L) && shift_l) begin
			cell_op = OP_SHIFT;
		end
	end

	assign div_done = (state_q == S_DIV) && !div_start_q && !busy_x && !busy_y && !busy_yaw;

	// Entry limit clamp on write
	always_comb begin
		lim_w = LW'(cfg_data[6:0]);
		if (lim_w < LW'(MIN_HELD)) begin
			lim_w = LW'(MIN_HELD);
		end else if (lim_w > LW'(MAX_ENTRIES)) begin
			lim_w = LW'(MAX_ENTRIES);
		end
	end

	// Control FSM and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			out_valid_q <= 1'b0;
			win_q       <= 63'd1000000000;
			lim_q       <= LIM_RESET;
			thr_q       <= 63'd1000000000;
			div_start_q <= 1'b0;
			op_q        <= OP_HOLD;
		end else begin
			div_start_q <= (state_q == S_DEC) && dec_div;
			if (cfg_en) begin
				unique case (cfg_addr)
					CFG_WINDOW:   win_q <= (cfg_data == '0) ? 63'd1 : cfg_data;
					CFG_LIMIT:    lim_q <= CW'(lim_w);
					CFG_ROLLBACK: thr_q <= (cfg_data == '0) ? 63'd1 : cfg_data;
					default: begin
					end
				endcase
			end
			// Output register: filled by a finished item, emptied by a transfer
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SEL;
					end
				end
				S_SEL: state_q <= S_DEC;
				S_DEC: begin
					op_q <= dec_op;
					if (req_q == REQ_PUSH) begin
						state_q <= S_APPLY;
					end else if (dec_div) begin
						state_q <= S_DIV;
					end else begin
						if (req_q != REQ_LOOKUP) begin
							n_q <= '0;
						end
						state_q <= S_DONE;
					end
				end
				S_APPLY: begin
					if (op_q == OP_INSERT) begin
						n_q     <= n_q + 1'b1;
						state_q <= S_PRUNE_W;
					end else begin
						if (op_q == OP_LOAD0) begin
							n_q <= CW'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_PRUNE_W: begin
					if (shift_w) begin
						n_q <= n_q - 1'b1;
					end else begin
						state_q <= S_PRUNE_L;
					end
				end
				S_PRUNE_L: begin
					if (shift_l) begin
						n_q <= n_q - 1'b1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request, selection and result datapath
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			req_q      <= in_data.req_type;
			rq_q.key   <= unsigned'(in_data.event_stamp) ^ KEY_FLIP;
			rq_q.x     <= unsigned'(in_data.pose_x_in);
			rq_q.y     <= unsigned'(in_data.pose_y_in);
			rq_q.yaw   <= unsigned'(in_data.pose_yaw_in);
		end
		if (state_q == S_SEL) begin
			newest_q <= newest_c;
			eq_any_q <= eq_any_c;
			eq_ent_q <= eq_ent_c;
			lo_ent_q <= lo_ent_c;
			hi_ent_q <= hi_ent_c;
			hi_in_q  <= hi_in_c;
			bnd0_q   <= st[0].bnd;
		end
		if (state_q == S_DEC) begin
			status_q <= dec_status;
			rx_q     <= dec_ready ? eq_ent_q.x : '0;
			ry_q     <= dec_ready ? eq_ent_q.y : '0;
			ryaw_q   <= dec_ready ? eq_ent_q.yaw : '0;
			cut_q    <= cut_after;
			num_q    <= rq_q.key - lo_ent_q.key;
			den_q    <= hi_ent_q.key - lo_ent_q.key;
			negx_q   <= dx[32];
			negy_q   <= dy[32];
			negyaw_q <= dyaw[15];
			magx_q   <= dx[32] ? 33'd0 - dx : dx;
			magy_q   <= dy[32] ? 33'd0 - dy : dy;
			magyaw_q <= dyaw[15] ? 16'd0 - dyaw : dyaw;
		end
		if (div_done) begin
			rx_q   <= lo_ent_q.x + 32'(negx_q ? 33'd0 - qx : qx);
			ry_q   <= lo_ent_q.y + 32'(negy_q ? 33'd0 - qy : qy);
			ryaw_q <= lo_ent_q.yaw + (negyaw_q ? 16'd0 - qyaw : qyaw);
		end
		if ((state_q == S_DONE) && out_free) begin
			out_q.status       <= status_q;
			out_q.pose_x_out   <= signed'(rx_q);
			out_q.pose_y_out   <= signed'(ry_q);
			out_q.pose_yaw_out <= signed'(ryaw_q);
			out_q.entry_count  <= 7'(n_q);
		end
	end

	// Interpolation scalers, one per pose component
	thpi_scale #(.MAG_W(33)) u_scale_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (num_q),
		.den    (den_q),
		.mag    (magx_q),
		.busy   (busy_x),
		.quo    (qx)
	);

	thpi_scale #(.MAG_W(33)) u_scale_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (num_q),
		.den    (den_q),
		.mag    (magy_q),
		.busy   (busy_y),
		.quo    (qy)
	);

	thpi_scale #(.MAG_W(16)) u_scale_yaw (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (num_q),
		.den    (den_q),
		.mag    (magyaw_q),
		.busy   (busy_yaw),
		.quo    (qyaw)
	);

	// Held count never exceeds the chain, and is within capacity once an item is done
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q <= CW'(NCELL)) && ((state_q != S_DONE) || (n_q <= CW'(MAX_ENTRIES))))
		else $error("held count out of range");

	// A finished item with room in the output register is presented next, and the FSM returns to idle
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && out_free |=> out_valid_q && (state_q == S_IDLE))
		else $error("result not presented");

	// Scalers run only during an interpolated lookup
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_x || busy_y || busy_yaw) |-> (state_q == S_DIV) && (req_q == REQ_LOOKUP))
		else $error("scaler busy outside lookup");

	// Pruning leaves at most the entry limit after an insertion
	a_prune_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PRUNE_L) && !shift_l |-> n_q <= lim_q)
		else $error("pruning exceeded entry limit");

endmodule

`default_nettype wire
